FILE: rtl/hsts_pkg.sv
// ----------------------------------------------------------------------------
// hsts_pkg
// shared types and constants for the hsts max-age header parser
// ----------------------------------------------------------------------------
package hsts_pkg;

   localparam int AGE_WIDTH = 31;   // width of the saturating age accumulator
   localparam int OUT_WIDTH = 31;   // width of the reported age field
   localparam int KEY_LEN   = 25;
   localparam int LIT_LEN   = 8;
   localparam int IDX_WIDTH = 5;

   localparam logic [AGE_WIDTH-1:0] AGE_LIMIT = '1;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3a;

   localparam logic [IDX_WIDTH-1:0] KEY_LAST = IDX_WIDTH'(KEY_LEN - 1);
   localparam logic [IDX_WIDTH-1:0] LIT_LAST = IDX_WIDTH'(LIT_LEN - 1);

   // "strict-transport-security", padded to the index range
   localparam logic [7:0] KEY_CHARS [32] = '{
      "s", "t", "r", "i", "c", "t", "-",
      "t", "r", "a", "n", "s", "p", "o", "r", "t", "-",
      "s", "e", "c", "u", "r", "i", "t", "y",
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // "max-age=", matched case-sensitive
   localparam logic [7:0] LIT_CHARS [8] = '{
      "m", "a", "x", "-", "a", "g", "e", "="
   };

   typedef enum logic [2:0] {
      PH_KEY,
      PH_COLON,
      PH_SPACES,
      PH_LIT,
      PH_DIGITS,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_STORE  = 2'd2
   } action_type;

   typedef struct packed {
      phase_type              phase;
      logic [IDX_WIDTH-1:0]   char_index;
      logic [AGE_WIDTH-1:0]   age_value;
      logic                   found;
      logic                   text_ended;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{
      phase:      PH_KEY,
      char_index: '0,
      age_value:  '0,
      found:      1'b0,
      text_ended: 1'b0
   };

endpackage

FILE: rtl/hsts_step.sv
// ----------------------------------------------------------------------------
// hsts_step
// next parser state for one header byte
// ----------------------------------------------------------------------------
module hsts_step (
   input  hsts_pkg::parse_state_type cur_state,
   input  logic [7:0]                byte_value,
   output hsts_pkg::parse_state_type next_state
);
   import hsts_pkg::*;

   logic [7:0]             lower_byte;
   logic                   lit_match;
   logic [2:0]             lit_idx;
   logic                   lit_in_range;
   logic [3:0]             digit;
   logic [AGE_WIDTH+3:0]   age_wide;
   logic [AGE_WIDTH+3:0]   limit_wide;

   always_comb begin
      lower_byte = byte_value;
      if (byte_value inside {["A":"Z"]}) begin
         lower_byte = byte_value + 8'h20;
      end
   end

   // spaces phase starts the literal at its first character
   assign lit_idx      = (cur_state.phase == PH_SPACES) ? 3'd0 : cur_state.char_index[2:0];
   assign lit_in_range = (cur_state.phase == PH_SPACES) ||
                         (cur_state.char_index <= LIT_LAST);

   // age * 10 + digit, wide enough for no wrap
   assign digit      = byte_value[3:0];
   assign age_wide   = ((AGE_WIDTH+4)'(cur_state.age_value) << 3) +
                       ((AGE_WIDTH+4)'(cur_state.age_value) << 1) +
                       (AGE_WIDTH+4)'(digit);
   assign limit_wide = (AGE_WIDTH+4)'(AGE_LIMIT);

   always_comb begin
      next_state = cur_state;
      lit_match  = 1'b0;
      if (cur_state.text_ended) begin
         next_state = cur_state;
      end else if (byte_value == CH_NUL) begin
         next_state.text_ended = 1'b1;
      end else if (byte_value == CH_LF) begin
         next_state.phase      = PH_KEY;
         next_state.char_index = '0;
      end else begin
         case (cur_state.phase)
            PH_KEY: begin
               if (cur_state.char_index <= KEY_LAST &&
                   lower_byte == KEY_CHARS[cur_state.char_index]) begin
                  if (cur_state.char_index == KEY_LAST) begin
                     next_state.phase      = PH_COLON;
                     next_state.char_index = '0;
                  end else begin
                     next_state.char_index = cur_state.char_index + 1'b1;
                  end
               end else begin
                  next_state.phase = PH_SKIP;
               end
            end
            PH_COLON: begin
               next_state.phase      = (byte_value == CH_COLON) ? PH_SPACES : PH_SKIP;
               next_state.char_index = '0;
            end
            PH_SPACES: begin
               if (byte_value != CH_SPACE) begin
                  lit_match = 1'b1;
               end
            end
            PH_LIT: begin
               lit_match = 1'b1;
            end
            PH_DIGITS: begin
               if (byte_value inside {["0":"9"]}) begin
                  next_state.age_value = (age_wide > limit_wide) ? AGE_LIMIT
                                         : age_wide[AGE_WIDTH-1:0];
               end else begin
                  next_state.phase = PH_SKIP;
               end
            end
            default: begin
               next_state = cur_state;
            end
         endcase

         if (lit_match) begin
            if (lit_in_range && byte_value == LIT_CHARS[lit_idx]) begin
               if (lit_idx == LIT_LAST[2:0]) begin
                  next_state.phase      = PH_DIGITS;
                  next_state.found      = 1'b1;
                  next_state.age_value  = '0;
                  next_state.char_index = '0;
               end else begin
                  next_state.phase      = PH_LIT;
                  next_state.char_index = IDX_WIDTH'(lit_idx) + 1'b1;
               end
            end else begin
               next_state.phase = PH_SKIP;
            end
         end
      end
   end

endmodule

FILE: rtl/hsts_max_age_header_parser.sv
// ----------------------------------------------------------------------------
// hsts_max_age_header_parser
// scans header text for a strict-transport-security max-age directive
// ----------------------------------------------------------------------------
// one beat per cycle in, back to back while req_stall is low; set by the
// single byte step between the parse state registers and the result register
// a result is registered in the cycle after the beat flagged end_of_block
// synchronous active-high reset clears parse state and the result valid
// after each report the parse state returns to its reset values
// ----------------------------------------------------------------------------
module hsts_max_age_header_parser (
   input  logic        clock,
   input  logic        reset,
   // header byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_header_byte,
   input  logic        req_end_of_block,
   // report channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_age_found,
   output logic [30:0] rsp_max_age_seconds,
   output logic [1:0]  rsp_policy_action
);
   import hsts_pkg::*;

   parse_state_type        state_ff;
   parse_state_type        state_in;
   parse_state_type        step_state;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   found_ff;
   logic                   found_in;
   logic [OUT_WIDTH-1:0]   age_ff;
   logic [OUT_WIDTH-1:0]   age_in;
   action_type             action_ff;
   action_type             action_in;

   logic                   req_beat;
   logic [AGE_WIDTH-1:0]   report_age;

   // byte step: all per-byte work sits in this one combinational stage
   hsts_step u_step (
      .cur_state  (state_ff),
      .byte_value (req_header_byte),
      .next_state (step_state)
   );

   // hold input only while a finished report is waiting and stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_beat  = req_valid & ~req_stall;

   // parse state: advance on every beat, back to reset after the final byte
   always_comb begin
      state_in = state_ff;
      if (req_beat) begin
         state_in = req_end_of_block ? PARSE_RESET : step_state;
      end
   end

   // report fields come from the state after the final byte is parsed
   assign report_age = step_state.found ? step_state.age_value : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      age_in       = age_ff;
      action_in    = action_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (req_beat && req_end_of_block) begin
         rsp_valid_in = 1'b1;
         found_in     = step_state.found;
         // masked to the field width after saturation
         age_in       = OUT_WIDTH'(report_age);
         if (!step_state.found) begin
            action_in = ACT_NONE;
         end else if (report_age == '0) begin
            action_in = ACT_REMOVE;
         end else begin
            action_in = ACT_STORE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PARSE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // report payload, no reset needed
   always_ff @(posedge clock) begin
      found_ff  <= found_in;
      age_ff    <= age_in;
      action_ff <= action_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_age_found       = found_ff;
   assign rsp_max_age_seconds = age_ff;
   assign rsp_policy_action   = action_ff;

endmodule

FILE: tb/sv/hsts_max_age_report_checker.sv
// ----------------------------------------------------------------------------
// hsts_max_age_report_checker
// follows the header byte channel, predicts each max-age report and checks
// every report beat against the oldest prediction
// ----------------------------------------------------------------------------
module hsts_max_age_report_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_header_byte,
   input  logic        req_end_of_block,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_age_found,
   input  logic [30:0] rsp_max_age_seconds,
   input  logic [1:0]  rsp_policy_action,
   output int          error_count,
   output int          reports_waiting,
   output int          reports_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import hsts_pkg::*;

   localparam logic [8*KEY_LEN-1:0] HSTS_KEY    = "strict-transport-security";
   localparam logic [8*LIT_LEN-1:0] AGE_TAG     = "max-age=";
   localparam logic [AGE_WIDTH-1:0] AGE_CEILING = {AGE_WIDTH{1'b1}};

   typedef struct packed {
      logic                 found;
      logic [OUT_WIDTH-1:0] age;
      action_type           action;
   } hsts_report_type;

   // shadow of the parser state
   phase_type            scan_phase;
   logic [IDX_WIDTH-1:0] scan_index;
   logic [AGE_WIDTH-1:0] scan_age;
   logic                 scan_found;
   logic                 scan_stopped;

   hsts_report_type report_q[$];
   int              fail_total;
   int              checked_total;

   task automatic clear_scan();
      scan_phase   = PH_KEY;
      scan_index   = '0;
      scan_age     = '0;
      scan_found   = 1'b0;
      scan_stopped = 1'b0;
   endtask

   task automatic note_error(input string msg);
      $display("[%0t] report mismatch: %s", $realtime, msg);
      fail_total++;
   endtask

   task automatic match_age_tag(input logic [7:0] b);
      if (int'(scan_index) < LIT_LEN &&
          b == AGE_TAG[8*(LIT_LEN-1-int'(scan_index)) +: 8]) begin
         if (int'(scan_index) == LIT_LEN-1) begin
            scan_phase = PH_DIGITS;
            scan_found = 1'b1;
            scan_age   = '0;
            scan_index = '0;
         end else begin
            scan_index = scan_index + 1'b1;
         end
      end else begin
         scan_phase = PH_SKIP;
      end
   endtask

   task automatic scan_byte(input logic [7:0] b);
      logic [7:0]      lower;
      longint unsigned grown;
      if (b == CH_NUL) begin
         scan_stopped = 1'b1;
      end else if (b == CH_LF) begin
         scan_phase = PH_KEY;
         scan_index = '0;
      end else begin
         case (scan_phase)
            PH_KEY: begin
               lower = b;
               if (b >= "A" && b <= "Z") lower = b + 8'd32;
               if (int'(scan_index) < KEY_LEN &&
                   lower == HSTS_KEY[8*(KEY_LEN-1-int'(scan_index)) +: 8]) begin
                  if (int'(scan_index) == KEY_LEN-1) begin
                     scan_phase = PH_COLON;
                     scan_index = '0;
                  end else begin
                     scan_index = scan_index + 1'b1;
                  end
               end else begin
                  scan_phase = PH_SKIP;
               end
            end
            PH_COLON: begin
               scan_phase = (b == CH_COLON) ? PH_SPACES : PH_SKIP;
               scan_index = '0;
            end
            PH_SPACES: begin
               if (b != CH_SPACE) begin
                  scan_phase = PH_LIT;
                  scan_index = '0;
                  match_age_tag(b);
               end
            end
            PH_LIT: match_age_tag(b);
            PH_DIGITS: begin
               if (b >= "0" && b <= "9") begin
                  grown = longint'(scan_age) * 10 + longint'(b - 8'h30);
                  if (grown > longint'(AGE_CEILING)) scan_age = AGE_CEILING;
                  else scan_age = grown[AGE_WIDTH-1:0];
               end else begin
                  scan_phase = PH_SKIP;
               end
            end
            default: ;
         endcase
      end
   endtask

   task automatic predict_report();
      hsts_report_type rep;
      rep.found = scan_found;
      rep.age   = scan_found ? OUT_WIDTH'(scan_age) : '0;
      if (!scan_found) rep.action = ACT_NONE;
      else if (scan_age == '0) rep.action = ACT_REMOVE;
      else rep.action = ACT_STORE;
      report_q.push_back(rep);
      clear_scan();
   endtask

   always @(posedge clock) begin
      hsts_report_type want;
      if (reset) begin
         clear_scan();
         report_q.delete();
         fail_total    = 0;
         checked_total = 0;
      end else begin
         // report side first: a report never answers the byte of this edge
         if (rsp_valid && !rsp_stall) begin
            checked_total++;
            if (report_q.size() == 0) begin
               note_error($sformatf("unexpected report found=%0d age=%0d action=%0d",
                  rsp_age_found, rsp_max_age_seconds, rsp_policy_action));
            end else begin
               want = report_q.pop_front();
               if (rsp_age_found !== want.found || rsp_max_age_seconds !== want.age ||
                   rsp_policy_action !== want.action) begin
                  note_error($sformatf("got found=%0d age=%0d action=%0d, want %0d/%0d/%0d",
                     rsp_age_found, rsp_max_age_seconds, rsp_policy_action,
                     want.found, want.age, want.action));
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (!scan_stopped) scan_byte(req_header_byte);
            if (req_end_of_block) predict_report();
         end
      end
      error_count     <= fail_total;
      reports_waiting <= report_q.size();
      reports_checked <= checked_total;
   end

endmodule

FILE: tb/sv/hsts_max_age_header_parser_test.sv
// ----------------------------------------------------------------------------
// hsts_max_age_header_parser_test
// drives header text blocks into the parser with random bursts and report
// stalls; a checker beside the block predicts and compares every report
// ----------------------------------------------------------------------------
module hsts_max_age_header_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hsts_pkg::*;

   localparam int RANDOM_BYTES = 1750;    // bytes in the random part
   localparam int CYCLE_LIMIT  = 400000;  // far beyond the slowest clean run
   localparam int DRAIN_CYCLES = 8;       // report is registered in the cycle after eob

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_header_byte  = 8'h00;
   logic        req_end_of_block = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic        rsp_age_found;
   logic [30:0] rsp_max_age_seconds;
   logic [1:0]  rsp_policy_action;

   int error_count;
   int reports_waiting;
   int reports_checked;

   int cycle_count = 0;
   int bytes_sent  = 0;
   int blocks_sent = 0;
   int burst_left  = 0;
   bit steady_block = 1'b0;   // block sent with no sender gaps at all
   int stall_mode  = 0;
   int stall_tick  = 0;

   logic [7:0] block_bytes[$];   // header text of the block being built

   hsts_max_age_header_parser u_top (.*);

   hsts_max_age_report_checker u_check (.*);

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // run-length watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d reports still due", cycle_count,
         reports_waiting);
      $display("hsts_max_age_header_parser_test: done, errors");
      $finish;
   end

   // report side stall pattern: one of four modes, picked anew at random
   // 0 never stall, 1 coin flip, 2 periodic, 3 mostly stalled
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 97 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= 1'($urandom_range(0, 1));
         2:       rsp_stall <= (stall_tick % 7) < 3;
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // sender idle: valid low; payload is junk while valid is low
   task automatic idle_cycle();
      @(negedge clock);
      req_valid        <= 1'b0;
      req_header_byte  <= 8'($urandom_range(0, 255));
      req_end_of_block <= 1'($urandom_range(0, 1));
   endtask

   // one byte beat, held until accepted; bursts end with a random gap
   task automatic send_beat(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = steady_block ? 0 : $urandom_range(0, 6);
         repeat (gap) idle_cycle();
      end
      burst_left--;
      @(negedge clock);
      req_valid        <= 1'b1;
      req_header_byte  <= b;
      req_end_of_block <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      bytes_sent++;
   endtask

   // send the built block, eob on its final byte
   task automatic send_block();
      for (int i = 0; i < block_bytes.size(); i++)
         send_beat(block_bytes[i], i == block_bytes.size() - 1);
      blocks_sent++;
      block_bytes.delete();
   endtask

   // hold off the sender until every report is in, plus the block latency
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (reports_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // append text, optionally with random upper case letters
   task automatic push_text(input string s, input bit mixed);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mixed && c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
         block_bytes.push_back(c);
      end
   endtask

   task automatic push_noise(input int n, input bit printable);
      repeat (n) block_bytes.push_back(printable ? 8'($urandom_range(32, 126))
                                                 : 8'($urandom_range(0, 255)));
   endtask

   // age digits, maybe after leading zeros: none, short, long, overflowing, right at the ceiling or a single zero
   task automatic add_digits();
      int pick;
      int n;
      pick = $urandom_range(0, 11);
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) push_text("0", 0);
      case (pick)
         0:       n = 0;
         1, 2, 3: n = $urandom_range(1, 3);
         4, 5, 6: n = $urandom_range(4, 9);
         7, 8:    n = $urandom_range(10, 13);
         9: begin
            push_text("2147483647", 0);
            n = 0;
         end
         10: begin
            push_text("2147483648", 0);
            n = 0;
         end
         default: begin
            push_text("0", 0);
            n = 0;
         end
      endcase
      repeat (n) block_bytes.push_back(8'($urandom_range(48, 57)));
   endtask

   // strict-transport-security line, with or without a usable max-age
   task automatic add_hsts_line(input bit with_tag);
      push_text("strict-transport-security", 1);
      block_bytes.push_back(CH_COLON);
      repeat ($urandom_range(0, 3)) block_bytes.push_back(CH_SPACE);
      if (with_tag) begin
         push_text("max-age=", 0);
         add_digits();
      end else begin
         // key matches but the directive does not
         case ($urandom_range(0, 3))
            0:       push_text("includeSubDomains", 0);
            1:       push_text("Max-Age=9", 0);
            2:       push_text("max-age 9", 0);
            default: push_text("max-ag=1", 0);
         endcase
      end
      // trailers: CR and parameters end the digits like any other byte
      case ($urandom_range(0, 3))
         0:       ;
         1:       block_bytes.push_back(8'h0d);
         2:       push_text("; includeSubDomains", 0);
         default: push_text("; preload", 0);
      endcase
   endtask

   // keys that are close to matching; most fail at some point, a random byte change may still match
   task automatic add_near_key();
      int start;
      start = block_bytes.size();
      push_text("strict-transport-security", 1);
      case ($urandom_range(0, 3))
         0: begin
            void'(block_bytes.pop_back());
            push_text(":max-age=5", 0);
         end
         1: push_text("x:max-age=5", 0);
         2: begin
            block_bytes[start + $urandom_range(0, KEY_LEN - 1)] =
               8'($urandom_range(1, 255));
            push_text(":max-age=7", 0);
         end
         default: push_text(" :max-age=1", 0);
      endcase
   endtask

   // one header line, mostly well formed
   task automatic add_line();
      int pick;
      int start;
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
         add_hsts_line(1'b1);
      end else if (pick < 10) begin
         add_hsts_line(1'b0);
      end else if (pick < 13) begin
         // well formed line with one byte hit by noise
         start = block_bytes.size();
         add_hsts_line(1'b1);
         block_bytes[$urandom_range(start, block_bytes.size() - 1)] =
            8'($urandom_range(0, 255));
      end else if (pick < 15) begin
         add_near_key();
      end else if (pick < 18) begin
         case ($urandom_range(0, 2))
            0:       push_text("content-type: text/html", 1);
            1:       push_text("Strict-Transport", 0);
            default: push_noise($urandom_range(1, 12), 1'b1);
         endcase
      end else begin
         push_noise($urandom_range(1, 8), 1'b0);
      end
   endtask

   // a header block of one to three lines, last LF optional, sometimes followed by a zero byte and one more line
   task automatic build_block();
      int lines;
      lines = $urandom_range(1, 3);
      for (int l = 0; l < lines; l++) begin
         add_line();
         if (l < lines - 1 || $urandom_range(0, 1)) block_bytes.push_back(CH_LF);
      end
      // text ended by a zero byte: the good line after it must be ignored
      if ($urandom_range(0, 7) == 0) begin
         block_bytes.push_back(CH_NUL);
         add_hsts_line(1'b1);
      end
   endtask

   initial begin
      int random_start;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: short blocks at the byte extremes
      block_bytes = '{8'h00};                    send_block();   // zero byte as last
      block_bytes = '{8'hff};                    send_block();
      block_bytes = '{CH_LF};                    send_block();
      block_bytes = '{"7"};                      send_block();   // digit, no key
      block_bytes = '{8'h00, 8'h7f, "x"};        send_block();   // bytes after the end
      block_bytes = '{"S", "t"};                 send_block();   // key cut short
      block_bytes = '{8'h55, 8'haa, 8'h01, 8'hfe}; send_block();
      block_bytes = '{8'h80, CH_COLON, CH_SPACE};  send_block();

      // sender waits here for every report
      drain();

      // random: well formed header blocks with noise and broken lines mixed in
      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         steady_block = ($urandom_range(0, 3) == 0);
         build_block();
         send_block();
         if ($urandom_range(0, 24) == 0) drain();
      end

      drain();

      $display("covered %0d header blocks in %0d bytes, %0d reports compared",
         blocks_sent, bytes_sent, reports_checked);
      if (error_count == 0) begin
         $display("hsts_max_age_header_parser_test: done, clean");
      end else begin
         $display("hsts_max_age_header_parser_test: done, errors");
      end
      $finish;
   end

endmodule
